@@ src/sibd_pkg.sv @@
// ----------------------------------------------------------------------------
// sibd_pkg
// Shared types and constants for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sibd_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int NUM_SYMS    = 16;
    localparam int DIGIT_DEPTH = 32;
    localparam int DIG_AW      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = DIG_AW + 1;
    localparam int DIG_W       = 4;
    localparam int VAL_W       = 32;
    localparam int BITS_PER_CYC = 8;
    localparam int DIV_CYCLES  = VAL_W / BITS_PER_CYC;
    localparam int STEP_W      = $clog2(DIV_CYCLES);

    localparam logic [4:0]  RADIX_RST  = 5'd10;
    localparam logic [63:0] SYM_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [63:0] SYM_HI_RST = 64'h4645_4443_4241_3938;

    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_FIRST_PRN = 8'd32;
    localparam logic [7:0] CHAR_DEL       = 8'd127;

    localparam logic [1:0] CFG_RADIX  = 2'd0;
    localparam logic [1:0] CFG_SYM_LO = 2'd1;
    localparam logic [1:0] CFG_SYM_HI = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ src/sibd_ram.sv @@
// ----------------------------------------------------------------------------
// sibd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sibd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/signed_int_to_base_digits_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_base_digits_core
// Flow: an accept step, then per digit a pass through the shared divide unit
//   (8 quotient bits a cycle), a sign step, then per digit a read out of the
//   digit RAM (read address, then registered data), and a step back to idle.
//   A word under a bad alphabet is accepted and dropped. One word at a time.
// Reset: synchronous, active low; radix back to 10, alphabet "0..9A..F";
//   digit RAM not cleared (every digit is written before it is read).
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_base_digits_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] character
    output logic             m_axis_tlast
);

    // configuration registers
    logic [4:0]  r_radix;
    logic [63:0] r_sym_lo;
    logic [63:0] r_sym_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= sibd_pkg::RADIX_RST;
            r_sym_lo <= sibd_pkg::SYM_LO_RST;
            r_sym_hi <= sibd_pkg::SYM_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sibd_pkg::CFG_RADIX:  r_radix  <= i_cfg_data[4:0];
                sibd_pkg::CFG_SYM_LO: r_sym_lo <= i_cfg_data;
                sibd_pkg::CFG_SYM_HI: r_sym_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // alphabet and radix in use
    logic [7:0] sym [sibd_pkg::NUM_SYMS];
    logic [4:0] rdx_use;
    logic       alpha_ok;

    always_comb begin
        logic [127:0] syms;
        syms = {r_sym_hi, r_sym_lo};
        for (int i = 0; i < sibd_pkg::NUM_SYMS; i++) begin
            sym[i] = syms[8*i +: 8];
        end
        rdx_use = (r_radix > 5'(sibd_pkg::MAX_RADIX)) ? 5'(sibd_pkg::MAX_RADIX) : r_radix;
    end

    always_comb begin
        alpha_ok = (rdx_use >= 5'd2);
        for (int i = 0; i < sibd_pkg::NUM_SYMS; i++) begin
            if (5'(i) < rdx_use) begin
                if (sym[i] < sibd_pkg::CHAR_FIRST_PRN || sym[i] >= sibd_pkg::CHAR_DEL ||
                    sym[i] == sibd_pkg::CHAR_MINUS || sym[i] == sibd_pkg::CHAR_PLUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = 0; j < i; j++) begin
                    if (sym[j] == sym[i]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // state
    sibd_pkg::t_state                r_state, n_state;
    logic [sibd_pkg::VAL_W-1:0]      r_mag, n_mag;
    logic [sibd_pkg::DIG_W-1:0]      r_rem, n_rem;
    logic [sibd_pkg::STEP_W-1:0]     r_step, n_step;
    logic [sibd_pkg::CNT_W-1:0]      r_count, n_count;
    logic [4:0]                      r_rdx, n_rdx;
    logic                            r_neg, n_neg;
    logic                            r_pend, n_pend;
    logic                            r_ovalid, n_ovalid;
    logic [7:0]                      r_char, n_char;
    logic                            r_last, n_last;

    // divide unit: eight restoring steps a cycle on the top byte
    logic [sibd_pkg::DIG_W-1:0]        div_rem;
    logic [sibd_pkg::BITS_PER_CYC-1:0] div_q;

    always_comb begin
        logic [sibd_pkg::DIG_W:0] t;
        div_rem = r_rem;
        div_q   = '0;
        for (int b = 0; b < sibd_pkg::BITS_PER_CYC; b++) begin
            t = {div_rem, r_mag[sibd_pkg::VAL_W-1-b]};
            if (t >= r_rdx) begin
                t = t - r_rdx;
                div_q[sibd_pkg::BITS_PER_CYC-1-b] = 1'b1;
            end
            div_rem = t[sibd_pkg::DIG_W-1:0];
        end
    end

    // digit RAM
    logic                             ram_we;
    logic [sibd_pkg::DIG_AW-1:0]      ram_waddr;
    logic [sibd_pkg::DIG_W-1:0]       ram_rdata;
    logic [sibd_pkg::CNT_W-1:0]       cnt_dec;
    logic [sibd_pkg::CNT_W-1:0]       cnt_inc;
    logic [sibd_pkg::VAL_W-1:0]       mag_next;

    assign cnt_dec   = r_count - sibd_pkg::CNT_W'(1);
    assign cnt_inc   = r_count + sibd_pkg::CNT_W'(1);
    assign ram_waddr = r_count[sibd_pkg::DIG_AW-1:0];
    assign mag_next  = {r_mag[sibd_pkg::VAL_W-sibd_pkg::BITS_PER_CYC-1:0], div_q};

    sibd_ram #(
        .WIDTH (sibd_pkg::DIG_W),
        .DEPTH (sibd_pkg::DIGIT_DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (div_rem),
        .i_raddr (cnt_dec[sibd_pkg::DIG_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_step   = r_step;
        n_count  = r_count;
        n_rdx    = r_rdx;
        n_neg    = r_neg;
        n_pend   = r_pend;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_char   = r_char;
        n_last   = r_last;
        ram_we   = 1'b0;
        s_axis_tready = (r_state == sibd_pkg::ST_IDLE);

        unique case (r_state)
            sibd_pkg::ST_IDLE: begin
                if (s_axis_tvalid && alpha_ok) begin
                    n_rdx   = rdx_use;
                    n_neg   = s_axis_tdata[sibd_pkg::VAL_W-1];
                    n_mag   = s_axis_tdata[sibd_pkg::VAL_W-1] ? (32'd0 - s_axis_tdata)
                                                              : s_axis_tdata;
                    n_count = '0;
                    n_step  = '0;
                    n_rem   = '0;
                    n_state = sibd_pkg::ST_DIV;
                end
            end
            sibd_pkg::ST_DIV: begin
                n_mag  = mag_next;
                n_rem  = div_rem;
                n_step = r_step + sibd_pkg::STEP_W'(1);
                if (r_step == sibd_pkg::STEP_W'(sibd_pkg::DIV_CYCLES - 1)) begin
                    ram_we  = 1'b1;
                    n_count = cnt_inc;
                    n_rem   = '0;
                    if (mag_next == '0 ||
                        cnt_inc == sibd_pkg::CNT_W'(sibd_pkg::DIGIT_DEPTH)) begin
                        n_state = sibd_pkg::ST_SIGN;
                    end
                end
            end
            sibd_pkg::ST_SIGN: begin
                if (!r_neg) begin
                    n_state = sibd_pkg::ST_EMIT;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = sibd_pkg::CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = sibd_pkg::ST_EMIT;
                end
            end
            sibd_pkg::ST_EMIT: begin
                if (r_pend) begin
                    n_pend   = 1'b0;
                    n_ovalid = 1'b1;
                    n_char   = sym[ram_rdata];
                    n_last   = (r_count == '0);
                end else if (r_count != '0 && out_free) begin
                    n_count = cnt_dec;
                    n_pend  = 1'b1;
                end else if (r_count == '0) begin
                    n_state = sibd_pkg::ST_IDLE;
                end
            end
            default: n_state = sibd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sibd_pkg::ST_IDLE;
            r_mag    <= '0;
            r_count  <= '0;
            r_step   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mag    <= n_mag;
            r_count  <= n_count;
            r_step   <= n_step;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_rdx  <= n_rdx;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_char;
    assign m_axis_tlast  = r_last;

    // read data lands only in an empty output register
    a_pend_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_ovalid)
        else $error("digit read pending while output word held");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sibd_pkg::ST_DIV) |-> ({1'b0, r_rem} < r_rdx))
        else $error("partial remainder not below radix");

    a_radix_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sibd_pkg::ST_DIV) |-> (r_rdx >= 5'd2))
        else $error("division running with radix below two");

    a_sign_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sibd_pkg::ST_SIGN) |-> (r_count != '0))
        else $error("no digits stored after division");

endmodule

`default_nettype wire

@@ dv/tb_signed_int_to_base_digits_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_base_digits_core
// Self-checking bench for the signed integer to radix text converter. A
// scoreboard keeps its own copy of radix and alphabet, predicts each
// character of every accepted value and compares the output words in order.
// Directed values at reset settings come first, then phases of random values
// under many radix and alphabet settings, including rejected ones. Both
// streams idle at random; one long output hold-off and one input pause.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_text_char;

class digit_text_scoreboard;
    logic [4:0]  radix_reg;
    logic [63:0] sym_lo;
    logic [63:0] sym_hi;
    t_text_char  expected_chars[$];
    int          errors;

    function new();
        radix_reg = sibd_pkg::RADIX_RST;
        sym_lo    = sibd_pkg::SYM_LO_RST;
        sym_hi    = sibd_pkg::SYM_HI_RST;
        errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] data);
        if (idx == sibd_pkg::CFG_RADIX) radix_reg = data[4:0];
        else if (idx == sibd_pkg::CFG_SYM_LO) sym_lo = data;
        else if (idx == sibd_pkg::CFG_SYM_HI) sym_hi = data;
    endfunction

    function logic [7:0] symbol(int unsigned i);
        logic [127:0] all;
        all = {sym_hi, sym_lo};
        return all[8*(i%16) +: 8];
    endfunction

    function bit alphabet_usable(int unsigned r);
        logic [7:0] c;
        if (r < 2) return 0;
        for (int unsigned i = 0; i < r; i++) begin
            c = symbol(i);
            if (c < sibd_pkg::CHAR_FIRST_PRN || c >= sibd_pkg::CHAR_DEL ||
                c == sibd_pkg::CHAR_MINUS || c == sibd_pkg::CHAR_PLUS)
                return 0;
            for (int unsigned j = 0; j < i; j++)
                if (symbol(j) == c) return 0;
        end
        return 1;
    endfunction

    // returns the number of characters expected for this value
    function int note_value(logic [31:0] v);
        int unsigned r;
        logic [31:0] mag;
        int unsigned digs[$];
        int n;
        r = (radix_reg > sibd_pkg::MAX_RADIX) ? sibd_pkg::MAX_RADIX : radix_reg;
        if (!alphabet_usable(r)) return 0;
        mag = v[31] ? (32'd0 - v) : v;
        if (mag == 0) begin
            expected_chars.push_back('{symbol(0), 1'b1});
            return 1;
        end
        while (mag != 0) begin
            digs.push_back(mag % r);
            mag = mag / r;
        end
        n = 0;
        if (v[31]) begin
            expected_chars.push_back('{sibd_pkg::CHAR_MINUS, 1'b0});
            n++;
        end
        for (int k = digs.size() - 1; k >= 0; k--) begin
            expected_chars.push_back('{symbol(digs[k]), k == 0});
            n++;
        end
        return n;
    endfunction

    function void check_char(logic [7:0] c, logic l);
        t_text_char e;
        if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected word char=%h last=%b", c, l);
            return;
        end
        e = expected_chars.pop_front();
        if (e.ch !== c || e.last !== l) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: exp char=%h last=%b, got char=%h last=%b",
                         e.ch, e.last, c, l);
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction
endclass

module tb_signed_int_to_base_digits_core;

    localparam int ITEM_TARGET  = 470;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    digit_text_scoreboard sb;
    bit quiet;
    bit hold_request;
    int sent_items;
    int cycles;

    signed_int_to_base_digits_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // output side: random stalls, plus the long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            m_axis_tready = (hold_left == 0) && (quiet || $urandom_range(99) >= 16);
            if (hold_left > 0) hold_left--;
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic send_value(input logic [31:0] v);
        while (!quiet && $urandom_range(99) < 16) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        do @(posedge i_clk); while (!s_axis_tready);
        void'(sb.note_value(v));
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = $urandom_range(20);
            1: v = 32'd0 - $urandom_range(20);
            2: case ($urandom_range(5))
                   0: v = 32'h0000_0000;
                   1: v = 32'h7FFF_FFFF;
                   2: v = 32'h8000_0000;
                   3: v = 32'h8000_0001;
                   4: v = 32'hFFFF_FFFF;
                   default: v = 32'h7FFF_FFFE;
               endcase
            3, 4: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = 32'd0 - v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // distinct printable non-sign symbols below r, anything above
    function automatic logic [127:0] random_alphabet(int unsigned r);
        logic [127:0] a;
        bit used[256];
        logic [7:0] c;
        for (int i = 0; i < 16; i++) begin
            if (i < r) begin
                do c = 8'($urandom_range(32, 126));
                while (used[c] || c == sibd_pkg::CHAR_MINUS || c == sibd_pkg::CHAR_PLUS);
                used[c] = 1'b1;
            end else begin
                c = 8'($urandom_range(255));
            end
            a[8*i +: 8] = c;
        end
        return a;
    endfunction

    function automatic logic [127:0] broken_alphabet(int unsigned r, int kind);
        logic [127:0] a;
        int unsigned p, q;
        a = random_alphabet(r);
        p = $urandom_range(r - 1);
        case (kind)
            0: a[8*p +: 8] = 8'($urandom_range(31));
            1: a[8*p +: 8] = sibd_pkg::CHAR_DEL;
            2: a[8*p +: 8] = 8'($urandom_range(128, 255));
            3: a[8*p +: 8] = sibd_pkg::CHAR_PLUS;
            4: a[8*p +: 8] = sibd_pkg::CHAR_MINUS;
            default: begin
                do q = $urandom_range(r - 1); while (q == p);
                a[8*p +: 8] = a[8*q +: 8];
            end
        endcase
        return a;
    endfunction

    task automatic run_phase(input logic [4:0] r, input logic [127:0] syms, input int n,
                             input bit no_idle, input int hold_at, input int pause_at);
        wait_idle();
        write_reg(sibd_pkg::CFG_RADIX, {59'd0, r});
        write_reg(sibd_pkg::CFG_SYM_LO, syms[63:0]);
        write_reg(sibd_pkg::CFG_SYM_HI, syms[127:64]);
        quiet = no_idle;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_request = 1'b1;
            if (i == pause_at) begin
                s_axis_tvalid = 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            send_value(pick_value());
        end
        s_axis_tvalid = 1'b0;
        quiet = 1'b0;
    endtask

    initial begin
        logic [31:0] directed[$];
        int unsigned r_eff;
        int phase_no;
        int bad_kind;
        logic [4:0] r;

        sb = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        sent_items   = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sibd_pkg::CFG_RADIX;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: decimal, extremes and edges of digit counts
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99,
                     32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'hFFFF_FFFE, 32'd12345, 32'hFFFE_7E33, 32'd255, 32'd256,
                     32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed[i]) send_value(directed[i]);
        s_axis_tvalid = 1'b0;

        // extremes of radix: binary with output hold-off, hex with input pause
        run_phase(5'd2, random_alphabet(2), 25, 1'b0, 4, -1);
        run_phase(5'd16, random_alphabet(16), 25, 1'b0, -1, 10);
        run_phase(5'd0, random_alphabet(16), 5, 1'b0, -1, -1);
        run_phase(5'd1, random_alphabet(16), 5, 1'b0, -1, -1);
        run_phase(5'd31, random_alphabet(16), 20, 1'b0, -1, -1);
        run_phase(5'd17, random_alphabet(16), 15, 1'b0, -1, -1);

        phase_no = 0;
        bad_kind = 0;
        while (sent_items < ITEM_TARGET) begin
            phase_no++;
            if (phase_no != 3 && $urandom_range(3) == 0) begin
                r = 5'($urandom_range(2, 31));
                r_eff = (r > sibd_pkg::MAX_RADIX) ? sibd_pkg::MAX_RADIX : r;
                if (bad_kind < 6)
                    run_phase(r, broken_alphabet(r_eff, bad_kind), 5, 1'b0, -1, -1);
                else if (bad_kind == 6)
                    run_phase(5'($urandom_range(1)), random_alphabet(16), 5, 1'b0, -1, -1);
                else
                    run_phase(5'($urandom_range(31)), {$urandom, $urandom, $urandom, $urandom},
                              5, 1'b0, -1, -1);
                bad_kind = (bad_kind + 1) % 8;
            end else begin
                r = 5'($urandom_range(2, 31));
                r_eff = (r > sibd_pkg::MAX_RADIX) ? sibd_pkg::MAX_RADIX : r;
                run_phase(r, random_alphabet(r_eff), $urandom_range(15, 35),
                          phase_no == 3, -1, -1);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
